FILE: rtl/ubs_pkg.sv
// shared types, request codes and saturation helper for the back-substitution solver
package ubs_pkg;

    localparam int WORD_W  = 32;
    localparam int ACC_W   = 64;
    localparam int SIZE_W  = 5;
    localparam int IDX_W   = 4;
    localparam int TYPE_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic [TYPE_W-1:0] REQ_LOAD_COEF = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_LOAD_RHS  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_SOLVE     = 2'd2;

    // +-(2^63-1) in 65-bit arithmetic
    localparam logic signed [ACC_W:0] POS_LIM65 = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] NEG_LIM65 = -POS_LIM65;

    typedef logic [SIZE_W-1:0] size_t;

    typedef struct packed {
        logic [TYPE_W-1:0]        req_type;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [WORD_W-1:0] load_value;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         solution_index;
        logic signed [WORD_W-1:0] solution_value;
        logic                     zero_pivot;
        logic                     last_result;
    } res_t;

    // clamp a 65-bit sum into the symmetric 64-bit range
    function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W:0] s);
        logic signed [ACC_W-1:0] r;
        if (s > POS_LIM65)
        begin
            r = POS_LIM65[ACC_W-1:0];
        end
        else if (s < NEG_LIM65)
        begin
            r = NEG_LIM65[ACC_W-1:0];
        end
        else
        begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/ubs_if.sv
// valid/ready channel interfaces for requests, results and the size register
interface ubs_req_if import ubs_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ubs_res_if import ubs_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ubs_cfg_if import ubs_pkg::*; ();
    logic  valid;
    logic  ready;
    size_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/upper_triangular_back_substitution.sv
// top level: upper-triangular back-substitution solver in signed fixed point
//
// channels: req takes load and solve beats, res gives one beat per solved row,
// cfg writes system_size (5 bits, 0 acts as 1, above MAX_SIZE acts as MAX_SIZE)
// a coefficient load writes R[row][col], an rhs load writes c[row]; load beats
// stream at one beat per clock while no solve is running
// a solve beat walks rows N-1 down to 0; row i costs N-1-i multiply-accumulate
// issues (one per cycle on the matrix ram read port), then diagonal fetch,
// pipeline drain and numerator setup, then the shared bit-serial divider, which
// stops early when the quotient overflows and is skipped on a zero diagonal,
// then the row write-back
// results come out last index first; last_result marks the row 0 beat
// req.ready is high only while no solve is running
// res has one output register: when the sink stalls, the solve pauses at the
// write-back of the next row until the held beat is taken
// reset: returns to idle, drops res.valid, sets system_size to 16; the rams
// are not cleared, entries must be loaded before a solve reads them
// x values are kept in the upper half of the vector ram, rhs in the lower half
module upper_triangular_back_substitution import ubs_pkg::*; #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ubs_cfg_if.sink   cfg,
    ubs_req_if.sink   req,
    ubs_res_if.source res
);

    localparam int AW = $clog2(MAX_SIZE);
    localparam int MW = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int BW = $clog2(2 * MAX_SIZE);

    localparam logic [AW-1:0] LAST_MAX = AW'(MAX_SIZE - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [AW-1:0]            i_reg;
    logic [AW-1:0]            i_next;
    logic [AW-1:0]            j_reg;
    logic [AW-1:0]            j_next;
    logic [AW-1:0]            last_reg;
    logic [AW-1:0]            last_next;
    logic                     rd_v_reg;
    logic                     rd_v_next;
    logic signed [ACC_W-1:0]  num_reg;
    logic signed [ACC_W-1:0]  num_next;
    logic                     zero_reg;
    logic                     zero_next;
    logic signed [WORD_W-1:0] x_reg;
    logic signed [WORD_W-1:0] x_next;
    logic                     res_valid_reg;
    res_t                     res_data_reg;
    size_t                    system_size_reg;

    logic                     req_fire;
    logic                     solve_go;
    logic                     row_ok;
    logic                     col_ok;
    logic                     wb_go;
    logic [AW-1:0]            clamp_last;

    // matrix ram
    logic              a_we;
    logic [MW-1:0]     a_waddr;
    logic [MW-1:0]     a_raddr;
    logic [WORD_W-1:0] a_rdata;

    // vector ram: rhs below MAX_SIZE, solution above
    logic              b_we;
    logic [BW-1:0]     b_waddr;
    logic [WORD_W-1:0] b_wdata;
    logic [BW-1:0]     b_raddr;
    logic [WORD_W-1:0] b_rdata;

    logic                     mac_clear;
    logic                     mac_busy;
    logic signed [ACC_W-1:0]  mac_acc;
    logic signed [ACC_W:0]    num_wide;

    logic                     div_start;
    logic                     div_done;
    logic signed [WORD_W-1:0] div_quo;

    // handshakes
    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid & req.ready;
    assign solve_go  = req_fire && (req.data.req_type == REQ_SOLVE);
    assign row_ok    = int'(req.data.row_index) < MAX_SIZE;
    assign col_ok    = int'(req.data.col_index) < MAX_SIZE;
    assign wb_go     = (state_reg == S_WB) && (!res_valid_reg || res.ready);

    // effective size minus one
    always_comb
    begin
        if (system_size_reg == '0)
        begin
            clamp_last = '0;
        end
        else if (int'(system_size_reg) > MAX_SIZE)
        begin
            clamp_last = LAST_MAX;
        end
        else
        begin
            clamp_last = AW'(system_size_reg - 1'b1);
        end
    end

    // load decode
    always_comb
    begin
        a_we = 1'b0;
        b_we = wb_go;
        if (req_fire)
        begin
            unique case (req.data.req_type)
                REQ_LOAD_COEF: a_we = row_ok && col_ok;
                REQ_LOAD_RHS:  b_we = row_ok;
                default:       a_we = 1'b0;
            endcase
        end
    end

    assign a_waddr = MW'(req.data.row_index) * MW'(MAX_SIZE) + MW'(req.data.col_index);
    // j equals i while the diagonal and rhs are fetched and held
    assign a_raddr = MW'(i_reg) * MW'(MAX_SIZE) + MW'(j_reg);
    assign b_waddr = wb_go ? (BW'(MAX_SIZE) + BW'(i_reg)) : BW'(req.data.row_index);
    assign b_wdata = wb_go ? x_reg : req.data.load_value;
    assign b_raddr = (j_reg == i_reg) ? BW'(i_reg) : (BW'(MAX_SIZE) + BW'(j_reg));

    ubs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SIZE * MAX_SIZE)
    ) u_mat_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (req.data.load_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    ubs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (2 * MAX_SIZE)
    ) u_vec_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // accumulator is cleared at the top of every row
    assign mac_clear = solve_go || (wb_go && i_reg != '0);

    ubs_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (mac_clear),
        .op_valid (rd_v_reg),
        .op_a     (signed'(a_rdata)),
        .op_b     (signed'(b_rdata)),
        .acc      (mac_acc),
        .busy     (mac_busy)
    );

    // c[i] scaled to the product format, minus the dot product
    assign num_wide = ((ACC_W+1)'(signed'(b_rdata)) <<< FRAC_BITS) - (ACC_W+1)'(mac_acc);

    assign div_start = (state_reg == S_DIV) && !zero_reg;

    ubs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (signed'(a_rdata)),
        .done  (div_done),
        .quo   (div_quo)
    );

    // row sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        last_next  = last_reg;
        num_next   = num_reg;
        zero_next  = zero_reg;
        x_next     = x_reg;
        rd_v_next  = (state_reg == S_MAC) && (j_reg != i_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (solve_go)
                begin
                    last_next  = clamp_last;
                    i_next     = clamp_last;
                    j_next     = clamp_last;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                // one product per cycle from column last down to i+1
                if (j_reg == i_reg)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            S_WAIT:
            begin
                if (!rd_v_reg && !mac_busy)
                begin
                    num_next   = sat_sum(num_wide);
                    zero_next  = (a_rdata == '0);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (zero_reg)
                begin
                    x_next     = '0;
                    state_next = S_WB;
                end
                else if (div_done)
                begin
                    x_next     = div_quo;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (wb_go)
                begin
                    if (i_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        j_next     = last_reg;
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            i_reg           <= '0;
            j_reg           <= '0;
            last_reg        <= '0;
            rd_v_reg        <= 1'b0;
            zero_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
            system_size_reg <= SIZE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            last_reg  <= last_next;
            rd_v_reg  <= rd_v_next;
            zero_reg  <= zero_next;
            if (cfg.valid)
            begin
                system_size_reg <= cfg.data;
            end
            if (wb_go)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        x_reg   <= x_next;
        if (wb_go)
        begin
            res_data_reg.solution_index <= IDX_W'(i_reg);
            res_data_reg.solution_value <= x_reg;
            res_data_reg.zero_pivot     <= zero_reg;
            res_data_reg.last_result    <= (i_reg == '0);
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

`ifndef SYNTHESIS
    // a row write-back always leaves a beat in the output register
    a_wb_beat: assert property (@(posedge clk) disable iff (!rst_n)
        wb_go |=> res_valid_reg)
        else $error("write-back without result beat");

    // the divider only finishes while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV) && !zero_reg)
        else $error("divider done outside divide state");

    // the column walk never passes the diagonal
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (j_reg >= i_reg) && (j_reg <= last_reg))
        else $error("column index out of range");

    // a read issued for the accumulator is consumed before the numerator is formed
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && $past(state_reg == S_WAIT) |-> !$past(rd_v_reg)
            && !$past(mac_busy))
        else $error("numerator formed before accumulator drained");
`endif

endmodule

FILE: rtl/ubs_ram.sv
// generic single-port-write ram with registered read
module ubs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ubs_mac.sv
// registered product and saturating accumulator
module ubs_mac import ubs_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  logic                     op_valid,
    input  logic signed [WORD_W-1:0] op_a,
    input  logic signed [WORD_W-1:0] op_b,
    output logic signed [ACC_W-1:0]  acc,
    output logic                     busy
);

    logic signed [ACC_W-1:0] prod_reg;
    logic                    prod_v_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = sat_sum((ACC_W+1)'(acc_reg) + (ACC_W+1)'(prod_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ACC_W'(op_a) * ACC_W'(op_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            prod_v_reg <= op_valid & ~clear;
            acc_reg    <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_v_reg;

endmodule

FILE: rtl/ubs_div.sv
// radix-2 restoring divider, 64 by 32 signed, quotient saturated to 32 bits
module ubs_div import ubs_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  num,
    input  logic signed [WORD_W-1:0] den,
    output logic                     done,
    output logic signed [WORD_W-1:0] quo
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;
    localparam logic [1:0] D_FIN  = 2'd3;

    localparam logic [WORD_W-1:0] HALF = {1'b1, {(WORD_W-1){1'b0}}};

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [4:0]                cnt_reg;
    logic [4:0]                cnt_next;
    logic                      neg_reg;
    logic                      ovf_reg;
    logic [ACC_W-1:0]          mag_reg;
    logic [WORD_W-1:0]         den_reg;
    logic [WORD_W-1:0]         rem_reg;
    logic [WORD_W-1:0]         rem_next;
    logic [WORD_W-1:0]         low_reg;
    logic [WORD_W-1:0]         low_next;
    logic [WORD_W:0]           trial;
    logic [WORD_W:0]           diff;

    assign trial = {rem_reg, low_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = D_CHK;
                end
            end
            D_CHK:
            begin
                rem_next   = mag_reg[ACC_W-1:WORD_W];
                low_next   = mag_reg[WORD_W-1:0];
                cnt_next   = '0;
                state_next = (mag_reg[ACC_W-1:WORD_W] >= den_reg) ? D_FIN : D_RUN;
            end
            D_RUN:
            begin
                if (!diff[WORD_W])
                begin
                    rem_next = diff[WORD_W-1:0];
                    low_next = {low_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[WORD_W-1:0];
                    low_next = {low_reg[WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = D_FIN;
                end
            end
            D_FIN:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            neg_reg <= num[ACC_W-1] ^ den[WORD_W-1];
            mag_reg <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
            den_reg <= den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
        end
        if (state_reg == D_CHK)
        begin
            ovf_reg <= mag_reg[ACC_W-1:WORD_W] >= den_reg;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quo = (ovf_reg || low_reg > HALF) ? signed'(HALF) : signed'(-low_reg);
        end
        else
        begin
            quo = (ovf_reg || low_reg[WORD_W-1]) ? signed'(~HALF) : signed'(low_reg);
        end
    end

    assign done = (state_reg == D_FIN);

endmodule
